[rtl/core/gra_pkg.sv]
// gra_pkg: shared types and constants of the grid rectangle allocator.
// No dependencies.
`default_nettype none
package gra_pkg;
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 8;
  localparam int ID_BITS     = 8;
  localparam int COL_BITS    = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int CELL_AW     = COL_BITS + ROW_BITS;
  localparam int CELL_DEPTH  = MAX_COLUMNS * MAX_ROWS;

  // configuration register indexes
  localparam logic [3:0] CFG_WIDTH  = 4'd0;
  localparam logic [3:0] CFG_HEIGHT = 4'd1;

  typedef enum logic [2:0] {
    MD_PLACE_AT = 3'd0,
    MD_FIRST_FIT = 3'd1,
    MD_REMOVE_AT = 3'd2,
    MD_REMOVE_ID = 3'd3,
    MD_PROBE = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BOUNDS = 3'd1,
    ST_NOROOM = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADID = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CAND, S_RD, S_CHK, S_FILL, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_FREE, PH_LOOK, PH_CLEAR, PH_PROBE
  } phase_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [CELL_AW-1:0] addr;
    logic [ID_BITS-1:0] wdata;
  } cell_req_t;
endpackage
`default_nettype wire

[rtl/core/gra_ram.sv]
// gra_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module gra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

[rtl/core/gra_cells.sv]
// gra_cells: cell owner store; RAM plus per-cell written flags so the grid reads empty after reset.
// Depends on gra_pkg and gra_ram.
`default_nettype none
module gra_cells import gra_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_req_t          req,
  output logic      [ID_BITS-1:0] rdata
);
  logic [CELL_DEPTH-1:0] vld_r;
  logic                  rd_vld_r;
  logic [ID_BITS-1:0]    ram_q;

  gra_ram #(.WIDTH(ID_BITS), .DEPTH(CELL_DEPTH)) u_ram (
    .clk   (clk),
    .rd_en (req.rd_en),
    .wr_en (req.wr_en),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_vld_r <= vld_r[req.addr];
    end
  end

  assign rdata = rd_vld_r ? ram_q : '0;
endmodule
`default_nettype wire

[rtl/core/grid_rectangle_allocator.sv]
// grid_rectangle_allocator: 2D occupancy grid, place / first-fit / remove / probe.
// Steps: each cell of a region is read, then checked; the cells to fill are then written in turn; S_DONE delivers.
// First fit: up to rows*cols candidates, each tried in turn with its region scan through the
// single cell RAM port. One transaction at a time.
// Reset (rst_n sync, low): grid empty via per-cell flags, width 12, height 5.
// Depends on gra_pkg and gra_cells.
`default_nettype none
module grid_rectangle_allocator import gra_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          in_mode,
  input  wire logic [7:0]          in_item_id,
  input  wire logic [4:0]          in_item_width,
  input  wire logic [3:0]          in_item_height,
  input  wire logic [3:0]          in_pos_x,
  input  wire logic [2:0]          in_pos_y,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_status,
  output logic [3:0]               out_placed_x,
  output logic [2:0]               out_placed_y,
  output logic [7:0]               out_found_id,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [3:0]          cfg_index,
  input  wire logic [4:0]          cfg_data
);
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [2:0] op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt, tgt_r, tgt_nxt;
  logic [4:0] w_r, w_nxt;
  logic [3:0] h_r, h_nxt;
  logic [4:0] gw_r, gw_nxt;
  logic [3:0] gh_r, gh_nxt;
  // region iterator
  logic [3:0] org_c_r, org_c_nxt, cur_c_r, cur_c_nxt;
  logic [2:0] org_r_r, org_r_nxt, cur_r_r, cur_r_nxt;
  logic [5:0] end_c_r, end_c_nxt;
  logic [4:0] end_r_r, end_r_nxt;
  // first-fit candidate
  logic [3:0] cand_c_r, cand_c_nxt;
  logic [2:0] cand_r_r, cand_r_nxt;
  // first hit of a remove-by-id sweep
  logic       hit_r, hit_nxt;
  logic [3:0] fx_r, fx_nxt;
  logic [2:0] fy_r, fy_nxt;
  // pending result
  logic [2:0] rs_r, rs_nxt;
  logic [3:0] rx_r, rx_nxt;
  logic [2:0] ry_r, ry_nxt;
  logic [7:0] rid_r, rid_nxt;
  // output register
  logic       ov_r, ov_nxt;
  logic [2:0] os_r, os_nxt;
  logic [3:0] ox_r, ox_nxt;
  logic [2:0] oy_r, oy_nxt;
  logic [7:0] oid_r, oid_nxt;

  cell_req_t          creq;
  logic [ID_BITS-1:0] cdata;
  logic               in_acc;
  logic               last_cell, cand_fits, cand_last, in_fits;
  logic [3:0]         cand_c_inc;
  logic [2:0]         cand_r_inc;

  gra_cells u_cells (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rdata (cdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign last_cell = ({2'b0, cur_c_r} + 6'd1 >= end_c_r) &&
                     ({2'b0, cur_r_r} + 5'd1 >= end_r_r);
  assign in_fits   = (in_item_width != '0) && (in_item_height != '0) &&
                     ({2'b0, in_pos_x} + {1'b0, in_item_width} <= {1'b0, gw_r}) &&
                     ({2'b0, in_pos_y} + {1'b0, in_item_height} <= {1'b0, gh_r});
  assign cand_fits = ({2'b0, cand_c_r} + {1'b0, w_r} <= {1'b0, gw_r}) &&
                     ({2'b0, cand_r_r} + {1'b0, h_r} <= {1'b0, gh_r});
  assign cand_c_inc = cand_c_r + 4'd1;
  assign cand_r_inc = cand_r_r + 3'd1;
  assign cand_last  = ({1'b0, cand_c_r} + 5'd1 >= gw_r) &&
                      ({1'b0, cand_r_r} + 4'd1 >= gh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gw_r    <= 5'd12;
      gh_r    <= 4'd5;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gw_r    <= gw_nxt;
      gh_r    <= gh_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;  op_r <= op_nxt;    id_r <= id_nxt;    tgt_r <= tgt_nxt;
    w_r <= w_nxt;          h_r <= h_nxt;
    org_c_r <= org_c_nxt;  org_r_r <= org_r_nxt;
    cur_c_r <= cur_c_nxt;  cur_r_r <= cur_r_nxt;
    end_c_r <= end_c_nxt;  end_r_r <= end_r_nxt;
    cand_c_r <= cand_c_nxt; cand_r_r <= cand_r_nxt;
    hit_r <= hit_nxt;      fx_r <= fx_nxt;    fy_r <= fy_nxt;
    rs_r <= rs_nxt;        rx_r <= rx_nxt;    ry_r <= ry_nxt;    rid_r <= rid_nxt;
    os_r <= os_nxt;        ox_r <= ox_nxt;    oy_r <= oy_nxt;    oid_r <= oid_nxt;
  end

  always_comb begin
    state_nxt = state_r;  phase_nxt = phase_r;  op_nxt = op_r;  id_nxt = id_r;
    tgt_nxt = tgt_r;      w_nxt = w_r;          h_nxt = h_r;
    gw_nxt = gw_r;        gh_nxt = gh_r;
    org_c_nxt = org_c_r;  org_r_nxt = org_r_r;  cur_c_nxt = cur_c_r;  cur_r_nxt = cur_r_r;
    end_c_nxt = end_c_r;  end_r_nxt = end_r_r;
    cand_c_nxt = cand_c_r; cand_r_nxt = cand_r_r;
    hit_nxt = hit_r;      fx_nxt = fx_r;        fy_nxt = fy_r;
    rs_nxt = rs_r;        rx_nxt = rx_r;        ry_nxt = ry_r;      rid_nxt = rid_r;
    ov_nxt = ov_r && out_stall;
    os_nxt = os_r;        ox_nxt = ox_r;        oy_nxt = oy_r;      oid_nxt = oid_r;
    creq = '{rd_en: 1'b0, wr_en: 1'b0, addr: {cur_r_r, cur_c_r}, wdata: '0};

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH) begin
        gw_nxt = (cfg_data > 5'(MAX_COLUMNS)) ? 5'(MAX_COLUMNS) : cfg_data;
      end else if (cfg_index == CFG_HEIGHT) begin
        gh_nxt = (cfg_data[3:0] > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : cfg_data[3:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_mode;  id_nxt = in_item_id;
          w_nxt = in_item_width;  h_nxt = in_item_height;
          rs_nxt = ST_OK;  rx_nxt = '0;  ry_nxt = '0;  rid_nxt = '0;
          hit_nxt = 1'b0;
          // default region: the given rectangle
          org_c_nxt = in_pos_x;  org_r_nxt = in_pos_y;
          cur_c_nxt = in_pos_x;  cur_r_nxt = in_pos_y;
          end_c_nxt = {2'b0, in_pos_x} + {1'b0, in_item_width};
          end_r_nxt = {2'b0, in_pos_y} + {1'b0, in_item_height};
          state_nxt = S_DONE;
          case (in_mode)
            MD_PLACE_AT: begin
              if (in_item_id == '0) rs_nxt = ST_BADID;
              else if (!in_fits) rs_nxt = ST_BOUNDS;
              else begin
                phase_nxt = PH_FREE;  state_nxt = S_RD;
              end
            end
            MD_FIRST_FIT: begin
              if (in_item_id == '0) rs_nxt = ST_BADID;
              else if (in_item_width == '0 || in_item_height == '0) rs_nxt = ST_BOUNDS;
              else if (gw_r == '0 || gh_r == '0) rs_nxt = ST_NOROOM;
              else begin
                cand_c_nxt = '0;  cand_r_nxt = '0;  state_nxt = S_CAND;
              end
            end
            MD_REMOVE_AT: begin
              if ({1'b0, in_pos_x} >= gw_r || {1'b0, in_pos_y} >= gh_r) rs_nxt = ST_BOUNDS;
              else begin
                end_c_nxt = {2'b0, in_pos_x} + 6'd1;
                end_r_nxt = {2'b0, in_pos_y} + 5'd1;
                phase_nxt = PH_LOOK;  state_nxt = S_RD;
              end
            end
            MD_REMOVE_ID: begin
              if (in_item_id == '0) rs_nxt = ST_BADID;
              else if (gw_r == '0 || gh_r == '0) rs_nxt = ST_NOTFOUND;
              else begin
                tgt_nxt = in_item_id;
                org_c_nxt = '0;  org_r_nxt = '0;  cur_c_nxt = '0;  cur_r_nxt = '0;
                end_c_nxt = {1'b0, gw_r};  end_r_nxt = {1'b0, gh_r};
                phase_nxt = PH_CLEAR;  state_nxt = S_RD;
              end
            end
            MD_PROBE: begin
              if (!in_fits) rs_nxt = ST_BOUNDS;
              else begin
                phase_nxt = PH_PROBE;  state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_CAND: begin
        if (cand_fits) begin
          org_c_nxt = cand_c_r;  org_r_nxt = cand_r_r;
          cur_c_nxt = cand_c_r;  cur_r_nxt = cand_r_r;
          end_c_nxt = {2'b0, cand_c_r} + {1'b0, w_r};
          end_r_nxt = {2'b0, cand_r_r} + {1'b0, h_r};
          phase_nxt = PH_FREE;  state_nxt = S_RD;
        end else if (cand_last) begin
          rs_nxt = ST_NOROOM;  state_nxt = S_DONE;
        end else if ({1'b0, cand_c_r} + 5'd1 < gw_r) begin
          cand_c_nxt = cand_c_inc;
        end else begin
          cand_c_nxt = '0;  cand_r_nxt = cand_r_inc;
        end
      end

      S_RD: begin
        creq.rd_en = 1'b1;
        state_nxt  = S_CHK;
      end

      S_CHK: begin
        // default: step to the next cell of the region in row-major order
        state_nxt = S_RD;
        if ({2'b0, cur_c_r} + 6'd1 < end_c_r) begin
          cur_c_nxt = cur_c_r + 4'd1;
        end else begin
          cur_c_nxt = org_c_r;  cur_r_nxt = cur_r_r + 3'd1;
        end
        case (phase_r)
          PH_FREE: begin
            if (cdata != '0) begin
              if (op_r == MD_PLACE_AT) begin
                rs_nxt = ST_NOROOM;  state_nxt = S_DONE;
              end else if (cand_last) begin
                rs_nxt = ST_NOROOM;  state_nxt = S_DONE;
              end else begin
                state_nxt = S_CAND;
                if ({1'b0, cand_c_r} + 5'd1 < gw_r) begin
                  cand_c_nxt = cand_c_inc;
                end else begin
                  cand_c_nxt = '0;  cand_r_nxt = cand_r_inc;
                end
              end
            end else if (last_cell) begin
              cur_c_nxt = org_c_r;  cur_r_nxt = org_r_r;  state_nxt = S_FILL;
            end
          end
          PH_LOOK: begin
            if (cdata == '0) begin
              rs_nxt = ST_NOTFOUND;  state_nxt = S_DONE;
            end else begin
              tgt_nxt = cdata;  rid_nxt = cdata;
              rx_nxt = org_c_r;  ry_nxt = org_r_r;
              org_c_nxt = '0;  org_r_nxt = '0;  cur_c_nxt = '0;  cur_r_nxt = '0;
              end_c_nxt = {1'b0, gw_r};  end_r_nxt = {1'b0, gh_r};
              phase_nxt = PH_CLEAR;
            end
          end
          PH_CLEAR: begin
            if (cdata == tgt_r) begin
              creq.wr_en = 1'b1;
              if (!hit_r) begin
                hit_nxt = 1'b1;  fx_nxt = cur_c_r;  fy_nxt = cur_r_r;
              end
            end
            if (last_cell) begin
              state_nxt = S_DONE;
              if (op_r == MD_REMOVE_ID) begin
                if (hit_r || cdata == tgt_r) begin
                  rid_nxt = tgt_r;
                  rx_nxt = hit_r ? fx_r : cur_c_r;
                  ry_nxt = hit_r ? fy_r : cur_r_r;
                end else begin
                  rs_nxt = ST_NOTFOUND;
                end
              end
            end
          end
          PH_PROBE: begin
            if (cdata != '0 && cdata != id_r) begin
              rx_nxt = cur_c_r;  ry_nxt = cur_r_r;  rid_nxt = cdata;
              state_nxt = S_DONE;
            end else if (last_cell) begin
              state_nxt = S_DONE;
            end
          end
          default: ;
        endcase
      end

      S_FILL: begin
        creq.wr_en = 1'b1;
        creq.wdata = id_r;
        if ({2'b0, cur_c_r} + 6'd1 < end_c_r) begin
          cur_c_nxt = cur_c_r + 4'd1;
        end else begin
          cur_c_nxt = org_c_r;  cur_r_nxt = cur_r_r + 3'd1;
        end
        if (last_cell) begin
          rx_nxt = org_c_r;  ry_nxt = org_r_r;  state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // hand the result to the output register once it is free
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          os_nxt = rs_r;  ox_nxt = rx_r;  oy_nxt = ry_r;  oid_nxt = rid_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid    = ov_r;
  assign out_status   = os_r;
  assign out_placed_x = ox_r;
  assign out_placed_y = oy_r;
  assign out_found_id = oid_r;

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_BADID))
    else $error("status code out of range");

  // Refusals carry no position and no id.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_placed_x == '0 && out_placed_y == '0 && out_found_id == '0))
    else $error("refused transaction carries payload");

  // An accepted transaction always leaves idle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accept");
endmodule
`default_nettype wire
